### hw/rtl/usp_pkg.sv
// URL syntax parser: shared types, constants and lookup functions.
package usp_pkg;

    localparam int NUM_SCHEMES = 10;
    localparam int NAME_SLOTS  = 8;

    typedef enum logic [4:0] {
        PH_SCHEME  = 5'd0,
        PH_SLASH1  = 5'd1,
        PH_SLASH2  = 5'd2,
        PH_HOST    = 5'd3,
        PH_PORT    = 5'd4,
        PH_PATH    = 5'd5,
        PH_QUERY   = 5'd6,
        PH_FRAG    = 5'd7,
        PH_MIME    = 5'd8,
        PH_B64_0   = 5'd9,
        PH_B64_1   = 5'd10,
        PH_B64_2   = 5'd11,
        PH_B64_3   = 5'd12,
        PH_B64_4   = 5'd13,
        PH_B64_5   = 5'd14,
        PH_COMMA   = 5'd15,
        PH_PAYLOAD = 5'd16
    } phase_t;

    // byte classes
    localparam logic [3:0] CLS_SCHEME  = 4'd0;
    localparam logic [3:0] CLS_DELIM   = 4'd1;
    localparam logic [3:0] CLS_HOST    = 4'd2;
    localparam logic [3:0] CLS_PORT    = 4'd3;
    localparam logic [3:0] CLS_PATH    = 4'd4;
    localparam logic [3:0] CLS_QUERY   = 4'd5;
    localparam logic [3:0] CLS_FRAG    = 4'd6;
    localparam logic [3:0] CLS_MIME    = 4'd7;
    localparam logic [3:0] CLS_B64     = 4'd8;
    localparam logic [3:0] CLS_PAYLOAD = 4'd9;
    localparam logic [3:0] CLS_ERROR   = 4'd10;

    // scheme codes
    localparam logic [3:0] SC_OTHER  = 4'd0;
    localparam logic [3:0] SC_HTTP   = 4'd1;
    localparam logic [3:0] SC_HTTPS  = 4'd2;
    localparam logic [3:0] SC_GEMINI = 4'd3;
    localparam logic [3:0] SC_IRC    = 4'd4;
    localparam logic [3:0] SC_IRCS   = 4'd5;
    localparam logic [3:0] SC_WS     = 4'd6;
    localparam logic [3:0] SC_WSS    = 4'd7;
    localparam logic [3:0] SC_FILE   = 4'd8;
    localparam logic [3:0] SC_ABOUT  = 4'd9;
    localparam logic [3:0] SC_DATA   = 4'd10;

    // part flag bits
    localparam int FB_SCHEME = 0;
    localparam int FB_HOST   = 1;
    localparam int FB_PORT   = 2;
    localparam int FB_PATH   = 3;
    localparam int FB_MIME   = 4;
    localparam int FB_B64    = 5;

    localparam logic [16:0] PORT_SAT = 17'h10000;

    localparam logic [2:0] SCHEME_LEN [NUM_SCHEMES] = '{
        3'd4, 3'd5, 3'd6, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4, 3'd5, 3'd4
    };

    localparam logic [7:0] SCHEME_CHR [NUM_SCHEMES][NAME_SLOTS] = '{
        '{8'h68, 8'h74, 8'h74, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00}, // http
        '{8'h68, 8'h74, 8'h74, 8'h70, 8'h73, 8'h00, 8'h00, 8'h00}, // https
        '{8'h67, 8'h65, 8'h6d, 8'h69, 8'h6e, 8'h69, 8'h00, 8'h00}, // gemini
        '{8'h69, 8'h72, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // irc
        '{8'h69, 8'h72, 8'h63, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00}, // ircs
        '{8'h77, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // ws
        '{8'h77, 8'h73, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, // wss
        '{8'h66, 8'h69, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00}, // file
        '{8'h61, 8'h62, 8'h6f, 8'h75, 8'h74, 8'h00, 8'h00, 8'h00}, // about
        '{8'h64, 8'h61, 8'h74, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00}  // data
    };

    typedef struct packed {
        phase_t      phase;
        logic [9:0]  match;
        logic [2:0]  len;
        logic [16:0] port;
        logic [5:0]  flags;
        logic        err;
    } usp_state_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] port;
        logic [3:0]  code;
        logic        b64;
        logic        defaulted;
    } usp_report_t;

    localparam usp_state_t STATE_RST = '{
        phase: PH_SCHEME,
        match: 10'h3ff,
        len:   3'd0,
        port:  17'd0,
        flags: 6'd0,
        err:   1'b0
    };

    // lowest-numbered surviving name of exactly the typed length
    function automatic logic [3:0] decode_scheme(input logic [9:0] match,
                                                 input logic [2:0] len);
        logic [3:0] code;
        code = SC_OTHER;
        for (int i = NUM_SCHEMES - 1; i >= 0; i--)
        begin
            if (match[i] && SCHEME_LEN[i] == len)
            begin
                code = 4'(i + 1);
            end
        end
        return code;
    endfunction

    function automatic logic [15:0] default_port(input logic [3:0] code);
        logic [15:0] p;
        case (code)
            SC_HTTP, SC_WS:    p = 16'd80;
            SC_HTTPS, SC_WSS:  p = 16'd443;
            SC_GEMINI:         p = 16'd1965;
            SC_IRC:            p = 16'd6667;
            SC_IRCS:           p = 16'd6697;
            default:           p = 16'd0;
        endcase
        return p;
    endfunction

    // expected letter of the ";base64," marker for each marker phase
    function automatic logic [7:0] b64_char(input phase_t ph);
        logic [7:0] ch;
        case (ph)
            PH_B64_0: ch = 8'h62;
            PH_B64_1: ch = 8'h61;
            PH_B64_2: ch = 8'h73;
            PH_B64_3: ch = 8'h65;
            PH_B64_4: ch = 8'h36;
            PH_B64_5: ch = 8'h34;
            default:  ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### hw/rtl/usp_in_if.sv
// URL parser input channel: one byte of URL text per transfer.
interface usp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_last;

    modport source (output valid, output char_in, output is_last, input ready);
    modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

### hw/rtl/usp_out_if.sv
// URL parser result channel: byte tag plus the end-of-URL report.
interface usp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  byte_class;
    logic        done_res;
    logic        url_valid;
    logic [15:0] port_out;
    logic [3:0]  scheme_code;
    logic        base64_flag;
    logic        path_defaulted;

    modport source (output valid, output byte_class, output done_res, output url_valid,
                    output port_out, output scheme_code, output base64_flag,
                    output path_defaulted, input ready);
    modport sink   (input valid, input byte_class, input done_res, input url_valid,
                    input port_out, input scheme_code, input base64_flag,
                    input path_defaulted, output ready);
endinterface

### hw/rtl/usp_step.sv
// Per-byte parse step: next parse state and byte class.
module usp_step (
    input  usp_pkg::usp_state_t st,
    input  logic [7:0]          char_in,
    output usp_pkg::usp_state_t nxt,
    output logic [3:0]          byte_class
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_Z     = 8'h7a;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_COMMA = 8'h2c;

    logic [3:0]  code_cur;
    logic [19:0] port_acc;
    logic        err;

    assign code_cur = usp_pkg::decode_scheme(st.match, st.len);
    assign port_acc = 20'(st.port) * 20'd10 + 20'(char_in - CH_0);

    always_comb
    begin
        nxt        = st;
        byte_class = usp_pkg::CLS_ERROR;
        err        = 1'b0;
        if (!st.err)
        begin
            case (st.phase)
                usp_pkg::PH_SCHEME:
                begin
                    if (char_in inside {[CH_A:CH_Z]})
                    begin
                        for (int i = 0; i < usp_pkg::NUM_SCHEMES; i++)
                        begin
                            if (st.len >= usp_pkg::SCHEME_LEN[i] ||
                                usp_pkg::SCHEME_CHR[i][st.len] != char_in)
                            begin
                                nxt.match[i] = 1'b0;
                            end
                        end
                        if (st.len != 3'd7)
                        begin
                            nxt.len = st.len + 3'd1;
                        end
                        nxt.flags[usp_pkg::FB_SCHEME] = 1'b1;
                        byte_class = usp_pkg::CLS_SCHEME;
                    end
                    else if (char_in == CH_COLON && st.len != 3'd0)
                    begin
                        if (code_cur == usp_pkg::SC_DATA)
                            nxt.phase = usp_pkg::PH_MIME;
                        else if (code_cur == usp_pkg::SC_ABOUT)
                            nxt.phase = usp_pkg::PH_PATH;
                        else
                            nxt.phase = usp_pkg::PH_SLASH1;
                        byte_class = usp_pkg::CLS_DELIM;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                usp_pkg::PH_SLASH1, usp_pkg::PH_SLASH2:
                begin
                    if (char_in == CH_SLASH)
                    begin
                        nxt.phase  = (st.phase == usp_pkg::PH_SLASH1) ?
                                     usp_pkg::PH_SLASH2 : usp_pkg::PH_HOST;
                        byte_class = usp_pkg::CLS_DELIM;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                usp_pkg::PH_HOST:
                begin
                    if (char_in != CH_NUL && char_in != CH_SLASH && char_in != CH_COLON)
                    begin
                        nxt.flags[usp_pkg::FB_HOST] = 1'b1;
                        byte_class = usp_pkg::CLS_HOST;
                    end
                    else if (!st.flags[usp_pkg::FB_HOST])
                    begin
                        // empty host is only legal for file, and starts the path
                        if (code_cur == usp_pkg::SC_FILE)
                        begin
                            nxt.phase = usp_pkg::PH_PATH;
                            nxt.flags[usp_pkg::FB_PATH] = 1'b1;
                            byte_class = usp_pkg::CLS_PATH;
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    else if (char_in == CH_COLON)
                    begin
                        nxt.phase  = usp_pkg::PH_PORT;
                        byte_class = usp_pkg::CLS_DELIM;
                    end
                    else if (char_in == CH_SLASH)
                    begin
                        nxt.phase = usp_pkg::PH_PATH;
                        nxt.flags[usp_pkg::FB_PATH] = 1'b1;
                        byte_class = usp_pkg::CLS_PATH;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                usp_pkg::PH_PORT:
                begin
                    if (char_in inside {[CH_0:CH_9]})
                    begin
                        nxt.port = (port_acc > 20'd65535) ? usp_pkg::PORT_SAT :
                                   port_acc[16:0];
                        nxt.flags[usp_pkg::FB_PORT] = 1'b1;
                        byte_class = usp_pkg::CLS_PORT;
                    end
                    else if (!st.flags[usp_pkg::FB_PORT] || st.port[16] ||
                             char_in != CH_SLASH)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        nxt.phase = usp_pkg::PH_PATH;
                        nxt.flags[usp_pkg::FB_PATH] = 1'b1;
                        byte_class = usp_pkg::CLS_PATH;
                    end
                end
                usp_pkg::PH_PATH:
                begin
                    if (char_in == CH_QMARK)
                    begin
                        nxt.phase  = usp_pkg::PH_QUERY;
                        byte_class = usp_pkg::CLS_DELIM;
                    end
                    else if (char_in == CH_HASH)
                    begin
                        nxt.phase  = usp_pkg::PH_FRAG;
                        byte_class = usp_pkg::CLS_DELIM;
                    end
                    else
                    begin
                        nxt.flags[usp_pkg::FB_PATH] = 1'b1;
                        byte_class = usp_pkg::CLS_PATH;
                    end
                end
                usp_pkg::PH_QUERY:
                begin
                    if (char_in == CH_HASH)
                    begin
                        nxt.phase  = usp_pkg::PH_FRAG;
                        byte_class = usp_pkg::CLS_DELIM;
                    end
                    else
                    begin
                        byte_class = usp_pkg::CLS_QUERY;
                    end
                end
                usp_pkg::PH_FRAG:
                begin
                    byte_class = usp_pkg::CLS_FRAG;
                end
                usp_pkg::PH_MIME:
                begin
                    if (char_in == CH_SEMI)
                    begin
                        nxt.phase  = usp_pkg::PH_B64_0;
                        byte_class = usp_pkg::CLS_DELIM;
                    end
                    else if (char_in == CH_COMMA)
                    begin
                        nxt.phase  = usp_pkg::PH_PAYLOAD;
                        byte_class = usp_pkg::CLS_DELIM;
                    end
                    else
                    begin
                        nxt.flags[usp_pkg::FB_MIME] = 1'b1;
                        byte_class = usp_pkg::CLS_MIME;
                    end
                end
                usp_pkg::PH_COMMA:
                begin
                    if (char_in == CH_COMMA)
                    begin
                        nxt.phase  = usp_pkg::PH_PAYLOAD;
                        byte_class = usp_pkg::CLS_DELIM;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                usp_pkg::PH_PAYLOAD:
                begin
                    byte_class = usp_pkg::CLS_PAYLOAD;
                end
                default:
                begin
                    if (st.phase inside {[usp_pkg::PH_B64_0:usp_pkg::PH_B64_5]} &&
                        usp_pkg::b64_char(st.phase) == char_in)
                    begin
                        if (st.phase == usp_pkg::PH_B64_5)
                        begin
                            nxt.flags[usp_pkg::FB_B64] = 1'b1;
                            nxt.phase = usp_pkg::PH_COMMA;
                        end
                        else
                        begin
                            nxt.phase = usp_pkg::phase_t'(st.phase + 5'd1);
                        end
                        byte_class = usp_pkg::CLS_B64;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
            endcase
            if (err)
            begin
                nxt.err    = 1'b1;
                byte_class = usp_pkg::CLS_ERROR;
            end
        end
    end

endmodule

### hw/rtl/usp_final.sv
// End-of-URL report: validity, port, scheme code and flags from the updated state.
module usp_final (
    input  usp_pkg::usp_state_t  st,
    output usp_pkg::usp_report_t rpt
);

    logic [3:0]  code;
    logic        ok;
    logic        defl;
    logic [15:0] port;

    always_comb
    begin
        code = (st.phase != usp_pkg::PH_SCHEME) ?
               usp_pkg::decode_scheme(st.match, st.len) : usp_pkg::SC_OTHER;
        ok   = !st.err;
        defl = 1'b0;
        case (st.phase)
            usp_pkg::PH_HOST:
            begin
                if (st.flags[usp_pkg::FB_HOST])
                    defl = 1'b1;
                else
                    ok = 1'b0;
            end
            usp_pkg::PH_PORT:
            begin
                if (st.port[16])
                    ok = 1'b0;
            end
            usp_pkg::PH_PATH, usp_pkg::PH_QUERY, usp_pkg::PH_FRAG, usp_pkg::PH_PAYLOAD:
            begin
                ok = ok;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        port = st.port[16] ? 16'd0 : st.port[15:0];
        if (port == 16'd0)
            port = usp_pkg::default_port(code);

        if (ok)
        begin
            if (code == usp_pkg::SC_ABOUT)
                ok = st.flags[usp_pkg::FB_PATH];
            else if (code == usp_pkg::SC_FILE)
                ok = st.flags[usp_pkg::FB_PATH] || defl;
            else if (code == usp_pkg::SC_DATA)
                ok = st.flags[usp_pkg::FB_MIME];
            else
                ok = st.flags[usp_pkg::FB_HOST];
        end

        rpt.valid     = ok;
        rpt.port      = ok ? port : 16'd0;
        rpt.code      = code;
        rpt.b64       = ok && st.flags[usp_pkg::FB_B64];
        rpt.defaulted = ok && defl;
    end

endmodule

### hw/rtl/url_syntax_parser_top.sv
// URL syntax parser top level: parse state registers and result register.
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  url_in   | in  | char_in[7:0], is_last
//  tag_out  | out | byte_class, done_res, url_valid, port_out, scheme_code,
//           |     | base64_flag, path_defaulted
//
// One byte per cycle; the result shows in the cycle after its byte is taken.
// The parse state and the result register are both written at the input
// transfer, so consecutive bytes need no gap. After a last byte the state
// returns to its reset values for the next URL. When tag_out stalls, one
// result is held and url_in.ready drops until it is taken.
module url_syntax_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    usp_in_if.sink     url_in,
    usp_out_if.source  tag_out
);

    usp_pkg::usp_state_t  st_reg;
    usp_pkg::usp_state_t  st_next;
    usp_pkg::usp_report_t rpt;
    logic [3:0]           cls;
    logic                 accept;
    logic                 out_valid_reg;

    logic [3:0]           byte_class_reg;
    logic                 done_reg;
    usp_pkg::usp_report_t rpt_reg;

    assign url_in.ready = !out_valid_reg || tag_out.ready;
    assign accept       = url_in.valid && url_in.ready;

    usp_step u_step (
        .st         (st_reg),
        .char_in    (url_in.char_in),
        .nxt        (st_next),
        .byte_class (cls)
    );

    usp_final u_final (
        .st  (st_next),
        .rpt (rpt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= usp_pkg::STATE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_reg <= url_in.is_last ? usp_pkg::STATE_RST : st_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (tag_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_class_reg <= cls;
            done_reg       <= url_in.is_last;
            rpt_reg        <= url_in.is_last ? rpt : '0;
        end
    end

    assign tag_out.valid          = out_valid_reg;
    assign tag_out.byte_class     = byte_class_reg;
    assign tag_out.done_res       = done_reg;
    assign tag_out.url_valid      = rpt_reg.valid;
    assign tag_out.port_out       = rpt_reg.port;
    assign tag_out.scheme_code    = rpt_reg.code;
    assign tag_out.base64_flag    = rpt_reg.b64;
    assign tag_out.path_defaulted = rpt_reg.defaulted;

endmodule
